@@ rtl/deq_pkg.sv @@
// shared types, widths and codes for the double-ended queue
`default_nettype none

package deq_pkg;

  // default depth of the ring store
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_REAR     = 3'd0,
    KIND_ADD_FRONT    = 3'd1,
    KIND_REMOVE_FRONT = 3'd2,
    KIND_REMOVE_REAR  = 3'd3,
    KIND_READ         = 3'd4,
    KIND_DROP         = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// bounded double-ended queue of signed words held in a ring store
// a request is taken into the input register, decoded from it, and its
//   result is registered in the result register before it is presented
// throughput: one request per cycle while m_tready does not hold the result,
//   set by the ring store, which is read or written once for each request
// reset: head index, element count and all valid flags clear; the ring
//   store is not cleared and needs no clearing pass
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // value [31:0], position [38:32], amount [45:39], zeros [47:46]
  input  wire logic [47:0] s_tdata,
  // kind [2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result_value [31:0], occupancy [38:32], zero [39]
  output logic [39:0]      m_tdata,
  // status [1:0]
  output logic [1:0]       m_tuser
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // ring wrap of head plus an offset below the capacity
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  // queue state and store
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [IW-1:0]      head;
  logic [CW-1:0]      cnt;
  logic [IW-1:0]      head_next;
  logic [CW-1:0]      cnt_next;

  // input stage
  logic               s1_valid;
  kind_t              s1_kind;
  logic [VALUE_W-1:0] s1_value;
  logic [POS_W-1:0]   s1_pos;
  logic [POS_W-1:0]   s1_amount;

  // result stage
  logic               out_valid;
  status_t            out_status;
  logic [CW-1:0]      out_occ;
  logic               out_use_rd;
  logic [VALUE_W-1:0] rd_data;

  logic               advance;
  logic               full;
  logic               empty;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      amt_x;
  logic [XW-1:0]      cnt_x;
  logic [IW-1:0]      off;
  logic [IW-1:0]      slot;
  logic [IW-1:0]      head_inc;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic               use_rd;
  status_t            status_next;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !s1_valid || advance;

  assign full  = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);
  assign pos_x = XW'(s1_pos);
  assign amt_x = XW'(s1_amount);
  assign cnt_x = XW'(cnt);

  assign slot     = wrap(head, off);
  assign head_inc = wrap(head, IW'(1));

  // decode of the request held in the input stage
  always_comb begin
    off         = '0;
    rd_addr     = slot;
    wr_en       = 1'b0;
    use_rd      = 1'b0;
    status_next = ST_OK;
    head_next   = head;
    cnt_next    = cnt;
    case (s1_kind)
      KIND_ADD_REAR: begin
        off = IW'(cnt);
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      KIND_ADD_FRONT: begin
        off = IW'(CAPACITY - 1);
        if (full) begin
          status_next = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_next = slot;
          cnt_next  = cnt + CW'(1);
        end
      end
      KIND_REMOVE_FRONT: begin
        rd_addr = head;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          use_rd    = 1'b1;
          head_next = head_inc;
          cnt_next  = cnt - CW'(1);
        end
      end
      KIND_REMOVE_REAR: begin
        off = IW'(cnt - CW'(1));
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          use_rd   = 1'b1;
          cnt_next = cnt - CW'(1);
        end
      end
      KIND_READ: begin
        off = IW'(pos_x - XW'(1));
        if (pos_x == '0 || pos_x > cnt_x) begin
          status_next = ST_EMPTY;
        end else begin
          use_rd = 1'b1;
        end
      end
      KIND_DROP: begin
        off = IW'(amt_x);
        if (amt_x >= cnt_x) begin
          cnt_next = '0;
        end else begin
          head_next = slot;
          cnt_next  = CW'(cnt_x - amt_x);
        end
      end
      default: begin
      end
    endcase
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      s1_kind   <= kind_t'(s_tuser);
      s1_value  <= s_tdata[31:0];
      s1_pos    <= s_tdata[38:32];
      s1_amount <= s_tdata[45:39];
    end
  end

  // head and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (s1_valid && advance) begin
      head <= head_next;
      cnt  <= cnt_next;
    end
  end

  // ring store port, read data registered
  always_ff @(posedge clk) begin
    if (s1_valid && advance && wr_en) begin
      mem[slot] <= s1_value;
    end
    if (advance) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_status <= status_next;
      out_occ    <= cnt_next;
      out_use_rd <= use_rd;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, OCC_W'(out_occ), (out_use_rd ? rd_data : '0)};
  assign m_tuser  = out_status;

  // checks on queue bookkeeping
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < IW'(CAPACITY) || CAPACITY == (1 << IW))
    else $error("head index outside the ring");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && full &&
     (s1_kind == KIND_ADD_REAR || s1_kind == KIND_ADD_FRONT))
    |=> (cnt == $past(cnt) && head == $past(head)))
    else $error("refused add changed the queue");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> out_occ == CW'(CAPACITY))
    else $error("full status without a full queue");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> !out_use_rd)
    else $error("word returned with a failing status");

endmodule

`default_nettype wire
